// ===== sv/isu_pkg.sv =====
`timescale 1ns / 1ps

package isu_pkg;

	localparam int MAX_ITEMS = 32;
	localparam int VALUE_W = 32;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_SHIFT  = 2'd2
	} cell_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	typedef struct packed {
		cell_mode_t          mode;
		logic [VALUE_W-1:0]  new_value;
	} cell_ctrl_t;

endpackage

// ===== sv/isu_ifs.sv =====
`timescale 1ns / 1ps

interface isu_in_if;
	logic                        valid;
	logic                        ready;
	logic [isu_pkg::VALUE_W-1:0] value;
	logic                        last_item;

	modport source (output valid, output value, output last_item, input ready);
	modport sink (input valid, input value, input last_item, output ready);
endinterface

interface isu_out_if;
	logic                        valid;
	logic                        ready;
	logic [isu_pkg::VALUE_W-1:0] sorted_value;
	logic                        end_of_set;
	logic                        overflowed;

	modport source (output valid, output sorted_value, output end_of_set,
		output overflowed, input ready);
	modport sink (input valid, input sorted_value, input end_of_set,
		input overflowed, output ready);
endinterface

// ===== sv/isu_cell.sv =====
`timescale 1ns / 1ps

module isu_cell (
	input  logic                        clk,
	input  isu_pkg::cell_ctrl_t         ctrl,
	input  logic                        occupied,
	input  logic                        left_gt,
	input  logic [isu_pkg::VALUE_W-1:0] left_value,
	input  logic [isu_pkg::VALUE_W-1:0] right_value,
	output logic                        gt,
	output logic [isu_pkg::VALUE_W-1:0] value
);

	logic [isu_pkg::VALUE_W-1:0] value_q;

	// An empty cell acts as if it held a value above every input.
	assign gt = !occupied || ($signed(value_q) > $signed(ctrl.new_value));
	assign value = value_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.mode)
			isu_pkg::CELL_INSERT: begin
				if (gt) begin
					value_q <= left_gt ? left_value : ctrl.new_value;
				end
			end
			isu_pkg::CELL_SHIFT: begin
				value_q <= right_value;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

endmodule

// ===== sv/insertion_sorter_unit.sv =====
`timescale 1ns / 1ps

// Streaming insertion sorter for signed 32-bit values. Each accepted item is
// placed into a chain of MAX_ITEMS compare-and-shift cells, unless it is full,
// after any stored values equal to it, so an item is accepted every cycle
// while a set is being collected. The item flagged last_item is inserted and
// then starts the read-out: the chain shifts toward its head one position per
// cycle, giving one sorted item per cycle when the sink is ready, with
// end_of_set on the final one and overflowed on every item of a set that lost
// values to a full chain. No input is accepted during the read-out; input
// resumes as soon as the final item sits in the output register.

module insertion_sorter_unit #(
	parameter int MAX_ITEMS = isu_pkg::MAX_ITEMS
) (
	input  logic              clk,
	input  logic              arst_n,
	isu_in_if.sink            in_ch,
	isu_out_if.source         out_ch
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	isu_pkg::state_t             state_q;
	logic [CNT_W-1:0]            count_q;
	logic                        dropped_q;
	logic                        out_valid_q;
	logic [isu_pkg::VALUE_W-1:0] out_value_q;
	logic                        out_end_q;
	logic                        out_ovf_q;

	logic                        accept;
	logic                        load;
	logic                        full;
	isu_pkg::cell_ctrl_t         ctrl;

	logic [isu_pkg::VALUE_W-1:0] cell_value [MAX_ITEMS];
	logic                        cell_gt    [MAX_ITEMS];

	assign in_ch.ready = (state_q == isu_pkg::ST_IDLE);
	assign accept = in_ch.valid && in_ch.ready;
	assign full = (count_q == CNT_W'(MAX_ITEMS));
	assign load = (state_q == isu_pkg::ST_EMIT) && (!out_valid_q || out_ch.ready);

	always_comb begin
		ctrl.new_value = in_ch.value;
		if (accept && !full) begin
			ctrl.mode = isu_pkg::CELL_INSERT;
		end else if (load) begin
			ctrl.mode = isu_pkg::CELL_SHIFT;
		end else begin
			ctrl.mode = isu_pkg::CELL_HOLD;
		end
	end

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic                        left_gt;
		logic [isu_pkg::VALUE_W-1:0] left_value;
		logic [isu_pkg::VALUE_W-1:0] right_value;

		if (i == 0) begin : g_head
			assign left_gt = 1'b0;
			assign left_value = in_ch.value;
		end else begin : g_body
			assign left_gt = cell_gt[i-1];
			assign left_value = cell_value[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign right_value = cell_value[i];
		end else begin : g_inner
			assign right_value = cell_value[i+1];
		end

		isu_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (CNT_W'(i) < count_q),
			.left_gt     (left_gt),
			.left_value  (left_value),
			.right_value (right_value),
			.gt          (cell_gt[i]),
			.value       (cell_value[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isu_pkg::ST_IDLE;
			count_q <= '0;
			dropped_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
				if (in_ch.last_item) begin
					state_q <= isu_pkg::ST_EMIT;
				end
			end
			if (load) begin
				count_q <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					state_q <= isu_pkg::ST_IDLE;
					dropped_q <= 1'b0;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_value_q <= cell_value[0];
			out_end_q <= (count_q == CNT_W'(1));
			out_ovf_q <= dropped_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.sorted_value = out_value_q;
	assign out_ch.end_of_set = out_end_q;
	assign out_ch.overflowed = out_ovf_q;

endmodule
